// ----- rtl/clipped_rect_fill_engine_macros.svh -----
// Assertion macros for the clipped rectangle fill engine checker.
// No dependencies; included by the checker file.
`ifndef CLIPPED_RECT_FILL_ENGINE_MACROS_SVH
`define CLIPPED_RECT_FILL_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CRFE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CRFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/crfe_pkg.sv -----
// Shared types and constants of the clipped rectangle fill engine.
// No dependencies; imported by every engine module except crfe_ram.
`default_nettype none

package crfe_pkg;

   // Field widths
   localparam int DIM_W  = 9;    // frame dimension registers
   localparam int PIX_W  = 32;   // one ARGB8888 pixel
   localparam int CW     = 20;   // signed working width of clip math
   localparam int RB_W   = 2 * DIM_W;

   // Divide by five: magnitude times reciprocal, then shift
   localparam int DIV_W       = 17;
   localparam int PROD_W      = 33;
   localparam int RECIP_SHIFT = 18;
   localparam logic [15:0] RECIP_FIVE = 16'd52429;

   // Command codes
   localparam logic [1:0] REQ_FILL  = 2'd0;
   localparam logic [1:0] REQ_BEVEL = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // Bevel rectangle select
   localparam logic [1:0] BOX_OUTER = 2'd0;
   localparam logic [1:0] BOX_RING  = 2'd1;
   localparam logic [1:0] BOX_INNER = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] rect_width;
      logic signed [15:0] rect_height;
      logic [31:0]        fill_color;
      logic [31:0]        border_color;
   } crfe_req_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic        read_valid;
   } crfe_rsp_type;

   // Clipped rectangle, inclusive bounds
   typedef struct packed {
      logic             hit;
      logic [DIM_W-1:0] x0;
      logic [DIM_W-1:0] x_last;
      logic [DIM_W-1:0] y0;
      logic [DIM_W-1:0] y_last;
   } crfe_box_type;

   typedef struct packed {
      logic       div_en;
      logic       inset_en;
      logic       clip_en;
      logic [1:0] sel;
   } crfe_box_ctrl_type;

   typedef struct packed {
      logic start_box;
      logic start_clear;
   } crfe_scan_ctrl_type;

   typedef struct packed {
      logic active;
      logic clearing;
      logic done;
   } crfe_scan_stat_type;

endpackage

`default_nettype wire

// ----- rtl/crfe_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module crfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/crfe_box.sv -----
// Rectangle geometry: bevel insets (divide by five) and clipping to the frame.
// Depends on crfe_pkg.
`default_nettype none

module crfe_box import crfe_pkg::*; (
   input  logic              clock,
   input  crfe_req_type      req,
   input  logic [DIM_W-1:0]  fw,
   input  logic [DIM_W-1:0]  fh,
   input  crfe_box_ctrl_type ctrl,
   output logic              gate,
   output crfe_box_type      box
);

   logic signed [CW-1:0] x_s, y_s, w_s, h_s, fw_s, fh_s;
   logic signed [CW-1:0] abs_w, abs_h;
   logic [DIV_W-1:0]     mag_w, mag_h;
   logic [PROD_W-1:0]    prod_w_ff, prod_h_ff, prod_w_in, prod_h_in;
   logic                 neg_w_ff, neg_h_ff;
   logic signed [CW-1:0] qw, qh;
   logic signed [CW-1:0] cs_ff, rs_ff, cs_in, rs_in;
   logic signed [CW-1:0] off_x, off_y;
   logic signed [CW-1:0] xs, xe, ys, ye, x0, y0, xend, yend;
   crfe_box_type         box_in, box_ff;

   // Operands in the signed working width
   always_comb begin
      x_s  = CW'($signed(req.x_pos));
      y_s  = CW'($signed(req.y_pos));
      w_s  = CW'($signed(req.rect_width));
      h_s  = CW'($signed(req.rect_height));
      fw_s = $signed(CW'(fw));
      fh_s = $signed(CW'(fh));
      gate = (x_s < fw_s) && (y_s < fh_s);
   end

   // Stage 1: magnitude times reciprocal of five
   always_comb begin
      abs_w     = w_s[CW-1] ? -w_s : w_s;
      abs_h     = h_s[CW-1] ? -h_s : h_s;
      mag_w     = DIV_W'(abs_w);
      mag_h     = DIV_W'(abs_h);
      prod_w_in = PROD_W'(mag_w) * PROD_W'(RECIP_FIVE);
      prod_h_in = PROD_W'(mag_h) * PROD_W'(RECIP_FIVE);
   end

   // Stage 2: quotient with the sign put back (truncation toward zero)
   always_comb begin
      qw    = $signed(CW'(prod_w_ff[PROD_W-1:RECIP_SHIFT]));
      qh    = $signed(CW'(prod_h_ff[PROD_W-1:RECIP_SHIFT]));
      cs_in = neg_w_ff ? -qw : qw;
      rs_in = neg_h_ff ? -qh : qh;
   end

   // Clip the selected nested rectangle
   always_comb begin
      unique case (ctrl.sel)
         BOX_OUTER: begin
            off_x = '0;
            off_y = '0;
         end
         BOX_RING: begin
            off_x = cs_ff;
            off_y = rs_ff;
         end
         BOX_INNER: begin
            off_x = cs_ff <<< 1;
            off_y = rs_ff <<< 1;
         end
         default: begin
            off_x = '0;
            off_y = '0;
         end
      endcase
      // start and exclusive end; the end is unchanged by cutting a negative start
      xs   = x_s + off_x;
      ys   = y_s + off_y;
      xe   = x_s + w_s - off_x;
      ye   = y_s + h_s - off_y;
      x0   = xs[CW-1] ? '0 : xs;
      y0   = ys[CW-1] ? '0 : ys;
      xend = (xe > fw_s) ? fw_s : xe;
      yend = (ye > fh_s) ? fh_s : ye;
      box_in.hit    = (xs < fw_s) && (ys < fh_s) && (xend > x0) && (yend > y0);
      box_in.x0     = x0[DIM_W-1:0];
      box_in.y0     = y0[DIM_W-1:0];
      box_in.x_last = DIM_W'(xend - 1);
      box_in.y_last = DIM_W'(yend - 1);
   end

   always_ff @(posedge clock) begin
      if (ctrl.div_en) begin
         prod_w_ff <= prod_w_in;
         prod_h_ff <= prod_h_in;
         neg_w_ff  <= w_s[CW-1];
         neg_h_ff  <= h_s[CW-1];
      end
      if (ctrl.inset_en) begin
         cs_ff <= cs_in;
         rs_ff <= rs_in;
      end
      if (ctrl.clip_en) begin
         box_ff <= box_in;
      end
   end

   assign box = box_ff;

endmodule

`default_nettype wire

// ----- rtl/crfe_scan.sv -----
// Raster scan of one clipped rectangle, and the full-store clearing sweep.
// Depends on crfe_pkg; drives the write port of the frame store.
`default_nettype none

module crfe_scan import crfe_pkg::*; #(
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  crfe_scan_ctrl_type ctrl,
   input  crfe_box_type       box,
   input  logic [DIM_W-1:0]   fw,
   output crfe_scan_stat_type status,
   output logic               mem_we,
   output logic [AW-1:0]      mem_addr
);

   logic             active_ff, active_in;
   logic             clearing_ff, clearing_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [AW-1:0]    row_ff, row_in;
   logic [DIM_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic             last_box, last_clr, done;

   // End of the current pass
   always_comb begin
      last_box = (cx_ff == box.x_last) && (cy_ff == box.y_last);
      last_clr = (clr_ff == AW'(DEPTH - 1));
      done     = active_ff && (clearing_ff ? last_clr : last_box);
   end

   // Next scan position
   always_comb begin
      active_in   = active_ff;
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      row_in      = row_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      priority if (ctrl.start_clear) begin
         active_in   = 1'b1;
         clearing_in = 1'b1;
         clr_in      = '0;
      end else if (ctrl.start_box) begin
         active_in   = 1'b1;
         clearing_in = 1'b0;
         cx_in       = box.x0;
         cy_in       = box.y0;
         row_in      = AW'(RB_W'(box.y0) * RB_W'(fw));
      end else if (active_ff) begin
         if (done) begin
            active_in = 1'b0;
         end else if (clearing_ff) begin
            clr_in = clr_ff + AW'(1);
         end else if (cx_ff == box.x_last) begin
            cx_in  = box.x0;
            cy_in  = cy_ff + DIM_W'(1);
            row_in = row_ff + AW'(fw);
         end else begin
            cx_in = cx_ff + DIM_W'(1);
         end
      end
   end

   // Reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b1;
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else begin
         active_ff   <= active_in;
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
      end
      row_ff <= row_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
   end

   always_comb begin
      mem_we          = active_ff;
      mem_addr        = clearing_ff ? clr_ff : row_ff + AW'(cx_ff);
      status.active   = active_ff;
      status.clearing = clearing_ff;
      status.done     = done;
   end

endmodule

`default_nettype wire

// ----- rtl/clipped_rect_fill_engine.sv -----
// Clipped rectangle fill engine: command sequencer, frame registers, frame store.
// Depends on crfe_pkg, crfe_ram, crfe_box and crfe_scan.
// Fill: clip, launch, scan if hit. Read: address, read, data. Clear: sweep whole store.
// Bevel: start test, done if outside the frame, else inset, then clip/launch/scan per box.
// One request at a time, next accepted as early as the result cycle; results cannot stall.
// Reset: synchronous; registers to 256, busy high through the clearing sweep.
`default_nettype none

module clipped_rect_fill_engine import crfe_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  crfe_req_type         req_data,
   output logic                 rsp_valid,
   output crfe_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_INSET  = 4'd3;
   localparam logic [3:0] S_CLIP   = 4'd4;
   localparam logic [3:0] S_LAUNCH = 4'd5;
   localparam logic [3:0] S_SCAN   = 4'd6;
   localparam logic [3:0] S_RADDR  = 4'd7;
   localparam logic [3:0] S_RREAD  = 4'd8;
   localparam logic [3:0] S_RWAIT  = 4'd9;
   localparam logic [3:0] S_CLEAR  = 4'd10;

   logic [3:0]         state_ff, state_in;
   crfe_req_type       req_ff, req_in;
   logic [1:0]         box_sel_ff, box_sel_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic               rd_hit_ff, rd_hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   crfe_rsp_type       rsp_ff, rsp_in;
   logic [DIM_W-1:0]   frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]   frame_height_ff, frame_height_in;
   logic [DIM_W-1:0]   fw_act, fh_act;
   logic [RB_W-1:0]    rd_idx;
   logic               more_boxes, finish;
   logic               gate;
   crfe_box_type       box;
   crfe_box_ctrl_type  box_ctrl;
   crfe_scan_ctrl_type scan_ctrl;
   crfe_scan_stat_type scan_stat;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [PIX_W-1:0]   mem_wdata, mem_rdata;

   // Frame registers
   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            default: ;
         endcase
      end
   end

   // Active frame: zero reads as one, above the store's size reads as the maximum
   always_comb begin
      priority if (frame_width_ff == '0) begin
         fw_act = DIM_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         fw_act = DIM_W'(MAX_WIDTH);
      end else begin
         fw_act = frame_width_ff;
      end
      priority if (frame_height_ff == '0) begin
         fh_act = DIM_W'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         fh_act = DIM_W'(MAX_HEIGHT);
      end else begin
         fh_act = frame_height_ff;
      end
   end

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      box_sel_in   = box_sel_ff;
      rd_addr_in   = rd_addr_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      finish       = 1'b0;
      more_boxes   = (req_ff.req_type == REQ_BEVEL) && (box_sel_ff != BOX_INNER);
      rd_idx       = RB_W'(req_ff.y_pos[DIM_W-1:0]) * RB_W'(fw_act)
                     + RB_W'(req_ff.x_pos[DIM_W-1:0]);
      unique case (state_ff)
         S_INIT: begin
            if (scan_stat.done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               box_sel_in = BOX_OUTER;
               unique case (req_data.req_type)
                  REQ_FILL:  state_in = S_CLIP;
                  REQ_BEVEL: state_in = S_DIV;
                  REQ_READ:  state_in = S_RADDR;
                  REQ_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            // whole-bevel start test
            if (gate) begin
               state_in = S_INSET;
            end else begin
               finish = 1'b1;
            end
         end
         S_INSET: begin
            state_in = S_CLIP;
         end
         S_CLIP: begin
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            if (box.hit) begin
               state_in = S_SCAN;
            end else if (more_boxes) begin
               box_sel_in = box_sel_ff + 2'd1;
               state_in   = S_CLIP;
            end else begin
               finish = 1'b1;
            end
         end
         S_SCAN: begin
            if (scan_stat.done) begin
               if (more_boxes) begin
                  box_sel_in = box_sel_ff + 2'd1;
                  state_in   = S_CLIP;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         S_RADDR: begin
            rd_hit_in  = !req_ff.x_pos[15] && !req_ff.y_pos[15]
                         && ($unsigned(req_ff.x_pos) < 16'(fw_act))
                         && ($unsigned(req_ff.y_pos) < 16'(fh_act));
            rd_addr_in = AW'(rd_idx);
            state_in   = S_RREAD;
         end
         S_RREAD: begin
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.pixel_value = rd_hit_ff ? mem_rdata : '0;
            rsp_in.read_valid  = rd_hit_ff;
            state_in           = S_IDLE;
         end
         S_CLEAR: begin
            if (scan_stat.done) begin
               finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // commands other than a read answer with zeros
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
      req_ff     <= req_in;
      box_sel_ff <= box_sel_in;
      rd_addr_ff <= rd_addr_in;
      rd_hit_ff  <= rd_hit_in;
      rsp_ff     <= rsp_in;
   end

   // Control of geometry and scan
   always_comb begin
      box_ctrl.div_en       = (state_ff == S_DIV);
      box_ctrl.inset_en     = (state_ff == S_INSET);
      box_ctrl.clip_en      = (state_ff == S_CLIP);
      box_ctrl.sel          = box_sel_ff;
      scan_ctrl.start_box   = (state_ff == S_LAUNCH) && box.hit;
      scan_ctrl.start_clear = (state_ff == S_IDLE) && start && (req_data.req_type == REQ_CLEAR);
      mem_wdata = scan_stat.clearing ? '0 :
                  (box_sel_ff == BOX_RING) ? req_ff.border_color : req_ff.fill_color;
   end

   crfe_box u_box (
      .clock (clock),
      .req   (req_ff),
      .fw    (fw_act),
      .fh    (fh_act),
      .ctrl  (box_ctrl),
      .gate  (gate),
      .box   (box)
   );

   crfe_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .box      (box),
      .fw       (fw_act),
      .status   (scan_stat),
      .mem_we   (mem_we),
      .mem_addr (mem_waddr)
   );

   crfe_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (state_ff == S_RREAD),
      .raddr (rd_addr_ff),
      .rdata (mem_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/crfe_checker.sv -----
// Port-level checks of the clipped rectangle fill engine, bound to the top level.
// Depends on crfe_pkg and clipped_rect_fill_engine_macros.svh.
`default_nettype none
`include "clipped_rect_fill_engine_macros.svh"

module crfe_checker import crfe_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input crfe_rsp_type rsp_data
);

   logic accepted, miss_rsp, zero_pix;

   assign accepted = start && !busy;
   assign miss_rsp = rsp_valid && !rsp_data.read_valid;
   assign zero_pix = (rsp_data.pixel_value == '0);

   // an accepted request is followed by a busy engine
   `CRFE_ASSERT_NEXT(a_accept_busy, clock, reset, accepted, busy, "accept without busy")

   // the result strobe lasts one cycle
   `CRFE_ASSERT_NEXT(a_rsp_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe held")

   // a result without a read hit carries a zero pixel
   `CRFE_ASSERT_SAME(a_rsp_zero, clock, reset, miss_rsp, zero_pix, "pixel without read hit")

   // a result only ends a command in progress
   `CRFE_ASSERT_SAME(a_rsp_cause, clock, reset, rsp_valid, $past(busy), "result while idle")

endmodule

bind clipped_rect_fill_engine crfe_checker u_crfe_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
